FILE: hdl/elrs_pkg.sv
package elrs_pkg;

  // Lattice size and register reset values.
  localparam int SITES_DEFAULT = 128;

  localparam logic [15:0] HOP_RIGHT_LIMIT_RESET = 16'd29789;
  localparam logic [15:0] HOP_LEFT_LIMIT_RESET  = 16'd59578;
  localparam logic [6:0]  HOME_SITE_RESET       = 7'd64;

  // Configuration register indexes.
  localparam logic [1:0] REG_HOP_RIGHT_LIMIT = 2'd0;
  localparam logic [1:0] REG_HOP_LEFT_LIMIT  = 2'd1;
  localparam logic [1:0] REG_HOME_SITE       = 2'd2;

  // Request types.
  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_MOVE = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  // Site contents. The fourth code is never stored.
  localparam logic [1:0] SITE_EMPTY    = 2'd0;
  localparam logic [1:0] SITE_PARTICLE = 2'd1;
  localparam logic [1:0] SITE_RESET    = 2'd2;
  localparam logic [1:0] SITE_INVALID  = 2'd3;

  // Event codes of a result.
  localparam logic [2:0] EV_NONE      = 3'd0;
  localparam logic [2:0] EV_HOP_RIGHT = 3'd1;
  localparam logic [2:0] EV_HOP_LEFT  = 3'd2;
  localparam logic [2:0] EV_INJECT    = 3'd3;
  localparam logic [2:0] EV_EXTRACT   = 3'd4;
  localparam logic [2:0] EV_RESET     = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_NBR,
    ST_SCAN,
    ST_SCAN_LAST,
    ST_CLRA,
    ST_DONE
  } state_t;

endpackage

FILE: hdl/elrs_if.sv
interface elrs_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [6:0]  site_index;
  logic [1:0]  site_value;
  logic [15:0] random_fraction;

  modport source (output valid, req_type, site_index, site_value, random_fraction,
                  input ready);
  modport sink (input valid, req_type, site_index, site_value, random_fraction,
                output ready);
endinterface

interface elrs_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic [1:0] read_value;

  modport source (output valid, event_res, read_value, input ready);
  modport sink (input valid, event_res, read_value, output ready);
endinterface

interface elrs_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reg_index;
  logic [15:0] reg_data;

  modport source (output valid, reg_index, reg_data, input ready);
  modport sink (input valid, reg_index, reg_data, output ready);
endinterface

FILE: hdl/elrs_lattice.sv
module elrs_lattice #(
  parameter int SITES = elrs_pkg::SITES_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     we,
  input  logic [$clog2(SITES)-1:0] waddr,
  input  logic [1:0]               wdata,
  input  logic [$clog2(SITES)-1:0] raddr,
  output logic [1:0]               rdata,
  output logic                     busy
);
  import elrs_pkg::*;

  localparam int IW = $clog2(SITES);
  localparam logic [IW-1:0] LAST = IW'(SITES - 1);

  logic [1:0]    mem [SITES];
  logic [IW-1:0] clr;

  // After reset every site is swept to empty, one per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      clr  <= '0;
    end else if (busy) begin
      clr <= clr + 1'b1;
      if (clr == LAST) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr] <= SITE_EMPTY;
    end else if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/exclusion_lattice_reset_step.sv
// Exclusion lattice with one reset particle, one request at a time.
// The request channel carries a load, a move attempt or a read for one site.
// Every request gives exactly one result on the result channel: the event
// that took place and the contents of the addressed site after the request.
// The configuration channel writes the two rate limits and the home site; it
// is always ready and should only be used while no request is in flight.
// A load or read steps through evaluate and done, as does a boundary inject or
// extract; a hop also reads the neighbor and clears the old site. A reset jump
// home checks every site between the particle and its home through the single
// lattice read port, one site per cycle, before it moves the particle.
// The block takes one request at a time and drops ready while it works on it.
// With a ready receiver the next request can be taken once it is back in idle.
// Results wait in an output register, so a new request can be accepted while
// the previous result is still held by a stalled receiver; a finished request
// waits for that register to empty before it returns to idle.
// After reset the lattice is swept to empty, one site per cycle; requests are
// held off until the sweep ends, while configuration writes are taken as usual.
module exclusion_lattice_reset_step #(
  parameter int SITES = elrs_pkg::SITES_DEFAULT
) (
  input logic    clk,
  input logic    rst,
  elrs_req_if.sink    request,
  elrs_res_if.source  result,
  elrs_cfg_if.sink    cfg
);
  import elrs_pkg::*;

  localparam int IW = $clog2(SITES);
  localparam logic [IW-1:0] LAST = IW'(SITES - 1);

  // Configuration registers.
  logic [15:0] hop_right_limit;
  logic [15:0] hop_left_limit;
  logic [6:0]  home_site;

  // Sequencer state and the captured request.
  state_t        state, state_next;
  logic [1:0]    req_r;
  logic [IW-1:0] a_r;
  logic [1:0]    val_r;
  logic [15:0]   rf_r;
  logic [IW-1:0] h_r;
  logic          home_ok;
  logic [1:0]    v_r;
  logic [IW-1:0] tgt, tgt_next;
  logic [IW-1:0] k, k_next;
  logic [IW-1:0] hi, hi_next;
  logic [2:0]    ev, ev_next;
  logic [1:0]    rd, rd_next;

  // Output register.
  logic       out_valid;
  logic [2:0] out_ev;
  logic [1:0] out_rd;

  // Lattice memory port.
  logic          lat_we;
  logic [IW-1:0] lat_waddr;
  logic [1:0]    lat_wdata;
  logic [IW-1:0] lat_raddr;
  logic [1:0]    lat_rdata;
  logic          lat_busy;

  logic          accept;
  logic          in_range;
  logic          b1, b2, b3;
  logic          is_first, is_last;
  logic          go_right, go_left, go_home;
  logic          a_below_h;
  logic [IW-1:0] scan_lo, scan_hi;

  elrs_lattice #(.SITES(SITES)) u_lattice (
    .clk   (clk),
    .rst   (rst),
    .we    (lat_we),
    .waddr (lat_waddr),
    .wdata (lat_wdata),
    .raddr (lat_raddr),
    .rdata (lat_rdata),
    .busy  (lat_busy)
  );

  assign cfg.ready     = 1'b1;
  assign request.ready = (state == ST_IDLE) && !lat_busy;
  assign accept        = request.valid && request.ready;
  assign in_range      = 32'(request.site_index) < SITES;

  assign result.valid      = out_valid;
  assign result.event_res  = out_ev;
  assign result.read_value = out_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      hop_right_limit <= HOP_RIGHT_LIMIT_RESET;
      hop_left_limit  <= HOP_LEFT_LIMIT_RESET;
      home_site       <= HOME_SITE_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.reg_index)
        REG_HOP_RIGHT_LIMIT: hop_right_limit <= cfg.reg_data;
        REG_HOP_LEFT_LIMIT:  hop_left_limit  <= cfg.reg_data;
        REG_HOME_SITE:       home_site       <= cfg.reg_data[6:0];
        default: ;
      endcase
    end
  end

  // Rate bands of the captured random fraction. Every comparison is strict,
  // so a fraction equal to a limit, or zero, falls in no band.
  assign b1 = (rf_r != 16'd0) && (rf_r < hop_right_limit);
  assign b2 = (rf_r > hop_right_limit) && (rf_r < hop_left_limit);
  assign b3 = rf_r > hop_left_limit;

  assign is_first = a_r == '0;
  assign is_last  = a_r == LAST;

  // The home jump needs the home site and every site strictly between it and
  // the particle to be empty, so the scan runs over that closed range.
  assign a_below_h = a_r < h_r;
  assign scan_lo   = a_below_h ? a_r + 1'b1 : h_r;
  assign scan_hi   = a_below_h ? h_r : a_r - 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DONE && (!out_valid || result.ready)) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r   <= request.req_type;
      a_r     <= IW'(request.site_index);
      val_r   <= request.site_value;
      rf_r    <= request.random_fraction;
      h_r     <= IW'(home_site);
      home_ok <= 32'(home_site) < SITES;
    end
    if (state == ST_EVAL) begin
      v_r <= lat_rdata;
    end
    if (state == ST_DONE && (!out_valid || result.ready)) begin
      out_ev <= ev;
      out_rd <= rd;
    end
    tgt <= tgt_next;
    k   <= k_next;
    hi  <= hi_next;
    ev  <= ev_next;
    rd  <= rd_next;
  end

  always_comb begin
    state_next = state;
    tgt_next   = tgt;
    k_next     = k;
    hi_next    = hi;
    ev_next    = ev;
    rd_next    = rd;
    lat_raddr  = a_r;
    lat_we     = 1'b0;
    lat_waddr  = a_r;
    lat_wdata  = SITE_EMPTY;
    go_right   = 1'b0;
    go_left    = 1'b0;
    go_home    = 1'b0;

    case (state)
      ST_IDLE: begin
        lat_raddr = IW'(request.site_index);
        if (accept) begin
          ev_next = EV_NONE;
          rd_next = SITE_EMPTY;
          state_next = in_range ? ST_EVAL : ST_DONE;
        end
      end

      // The site's contents have arrived; decide what the request does.
      ST_EVAL: begin
        rd_next    = lat_rdata;
        ev_next    = EV_NONE;
        state_next = ST_DONE;
        case (req_r)
          REQ_LOAD: begin
            if (val_r != SITE_INVALID) begin
              lat_we    = 1'b1;
              lat_wdata = val_r;
              rd_next   = val_r;
            end
          end
          REQ_MOVE: begin
            if (is_first) begin
              if (lat_rdata == SITE_EMPTY) begin
                if (b1) begin
                  lat_we    = 1'b1;
                  lat_wdata = SITE_PARTICLE;
                  ev_next   = EV_INJECT;
                  rd_next   = SITE_PARTICLE;
                end
              end else if (lat_rdata == SITE_PARTICLE) begin
                if (b2) begin
                  lat_we  = 1'b1;
                  ev_next = EV_EXTRACT;
                  rd_next = SITE_EMPTY;
                end else if (b1) begin
                  go_right = 1'b1;
                end
              end else if (b3) begin
                go_home = 1'b1;
              end
            end else if (is_last) begin
              if (lat_rdata == SITE_EMPTY) begin
                if (b2) begin
                  lat_we    = 1'b1;
                  lat_wdata = SITE_PARTICLE;
                  ev_next   = EV_INJECT;
                  rd_next   = SITE_PARTICLE;
                end
              end else if (lat_rdata == SITE_PARTICLE) begin
                if (b1) begin
                  lat_we  = 1'b1;
                  ev_next = EV_EXTRACT;
                  rd_next = SITE_EMPTY;
                end else if (b2) begin
                  go_left = 1'b1;
                end
              end else if (b3) begin
                go_home = 1'b1;
              end
            end else if (lat_rdata != SITE_EMPTY) begin
              if (b1) begin
                go_right = 1'b1;
              end else if (b2) begin
                go_left = 1'b1;
              end else if (b3 && lat_rdata == SITE_RESET) begin
                go_home = 1'b1;
              end
            end
          end
          default: ;
        endcase

        if (go_right || go_left) begin
          tgt_next   = go_right ? a_r + 1'b1 : a_r - 1'b1;
          lat_raddr  = tgt_next;
          ev_next    = go_right ? EV_HOP_RIGHT : EV_HOP_LEFT;
          state_next = ST_NBR;
        end else if (go_home && home_ok && h_r != a_r) begin
          tgt_next   = h_r;
          hi_next    = scan_hi;
          lat_raddr  = scan_lo;
          k_next     = scan_lo + 1'b1;
          ev_next    = EV_RESET;
          state_next = (scan_lo == scan_hi) ? ST_SCAN_LAST : ST_SCAN;
        end
      end

      // Neighbor contents have arrived: hop only into an empty site.
      ST_NBR: begin
        if (lat_rdata == SITE_EMPTY) begin
          lat_we     = 1'b1;
          lat_waddr  = tgt;
          lat_wdata  = v_r;
          state_next = ST_CLRA;
        end else begin
          ev_next    = EV_NONE;
          state_next = ST_DONE;
        end
      end

      // One read per cycle; each cycle checks the site read the cycle before.
      ST_SCAN: begin
        lat_raddr = k;
        if (lat_rdata != SITE_EMPTY) begin
          ev_next    = EV_NONE;
          state_next = ST_DONE;
        end else if (k == hi) begin
          state_next = ST_SCAN_LAST;
        end else begin
          k_next = k + 1'b1;
        end
      end

      ST_SCAN_LAST: begin
        if (lat_rdata == SITE_EMPTY) begin
          lat_we     = 1'b1;
          lat_waddr  = tgt;
          lat_wdata  = v_r;
          state_next = ST_CLRA;
        end else begin
          ev_next    = EV_NONE;
          state_next = ST_DONE;
        end
      end

      // The moving particle leaves its original site.
      ST_CLRA: begin
        lat_we     = 1'b1;
        rd_next    = SITE_EMPTY;
        state_next = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid || result.ready) begin
          state_next = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

`ifndef NO_ASSERTIONS
  // No request may be taken while the lattice is still being cleared.
  assert property (@(posedge clk) disable iff (rst) lat_busy |-> !request.ready)
    else $error("request accepted during lattice clear");

  // The unused site code must never reach the lattice.
  assert property (@(posedge clk) disable iff (rst) lat_we |-> lat_wdata != SITE_INVALID)
    else $error("invalid site code written");

  // A particle that leaves the addressed site leaves it empty.
  assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.event_res == EV_HOP_RIGHT || result.event_res == EV_HOP_LEFT ||
                     result.event_res == EV_EXTRACT || result.event_res == EV_RESET)
    |-> result.read_value == SITE_EMPTY)
    else $error("site not empty after a departure");

  // An injected particle shows up at the addressed site.
  assert property (@(posedge clk) disable iff (rst)
    result.valid && result.event_res == EV_INJECT |-> result.read_value == SITE_PARTICLE)
    else $error("site not filled after an inject");

  // An accepted request always moves the sequencer out of idle.
  assert property (@(posedge clk) disable iff (rst) accept |=> state != ST_IDLE)
    else $error("sequencer stayed idle after a request");
`endif

endmodule
